/* sv/rsld_pkg.sv */
// rsld_pkg: shared constants, types and the cosine table of the ring sensor
// line direction block; no dependencies
`timescale 1ns / 1ps

package rsld_pkg;

    localparam int SENSOR_COUNT  = 32;
    localparam int FRACTION_BITS = 14;
    localparam int ACC_BITS      = 30;
    localparam int LANE_COUNT    = 4;

    localparam int MASK_W  = 32;
    localparam int DIR_W   = 16;
    localparam int COUNT_W = 9;

    localparam int SENSOR_W    = $clog2(SENSOR_COUNT);
    localparam int BLK_COUNT   = SENSOR_COUNT / LANE_COUNT;
    localparam int BLK_W       = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
    localparam int SWEEP_W     = SENSOR_W + BLK_W;
    localparam int COS_ENTRIES = 4 * SENSOR_COUNT;
    localparam int COS_IDX_W   = $clog2(COS_ENTRIES);
    localparam int H_W         = SENSOR_W + 3;
    localparam int Q_W         = ACC_BITS + 2;
    localparam int MAG_W       = ACC_BITS + 1;
    localparam int PAIR_MAX    = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
    localparam int CNT_W       = $clog2(PAIR_MAX + 1);
    localparam int LCNT_W      = $clog2(LANE_COUNT + 1);
    localparam int ACC_W       = Q_W + CNT_W;
    localparam int DIV_SHIFT   = ACC_BITS - FRACTION_BITS;
    localparam int DIVISOR_W   = CNT_W + DIV_SHIFT;
    localparam int DSTEP_W     = $clog2(ACC_W);
    localparam int DRAIN_W     = 2;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(2);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int TAYLOR_TERMS = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    // per-item context shared by all lanes
    typedef struct packed {
        logic [SENSOR_COUNT-1:0] mask;
        logic                    single_run;
        logic                    lone_mode;
        logic [SENSOR_W-1:0]     lone_idx;
        logic [SENSOR_W-1:0]     a;
        logic                    issue;
    } lane_ctx_t;

    typedef struct packed {
        logic                  valid;
        logic signed [Q_W-1:0] px;
        logic signed [Q_W-1:0] py;
    } lane_out_t;

    typedef logic signed [Q_W-1:0] cos_table_t [COS_ENTRIES];

    // unsigned shift-subtract quotient, elaboration only
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 0;
        r = 0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos(k*pi/(2N)) in Q30 by integer taylor series, elaboration only
    function automatic longint cos_units(int k);
        longint unsigned quarter;
        longint unsigned half;
        longint unsigned full;
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rnd;
        longint          acc;
        longint          one;
        logic            neg;
        int              n;
        quarter = longint'(SENSOR_COUNT);
        half    = 2 * quarter;
        full    = 4 * quarter;
        rnd     = 64'd1 << (ACC_BITS - 1);
        one     = 64'sd1 << ACC_BITS;
        neg     = 1'b0;
        kk      = longint'(k) - udiv(longint'(k), full) * full;
        if (kk > half)
            kk = full - kk;
        if (kk > quarter) begin
            neg = 1'b1;
            kk  = half - kk;
        end
        if (kk == quarter)
            return 0;
        x    = udiv(kk * PI_Q30 + quarter, half);
        x2   = (x * x + rnd) >> ACC_BITS;
        term = 64'd1 << ACC_BITS;
        acc  = one;
        for (n = 1; n <= TAYLOR_TERMS; n++) begin
            term = udiv((term * x2 + rnd) >> ACC_BITS, longint'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > one)
            acc = one;
        return neg ? -acc : acc;
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t t;
        int         i;
        for (i = 0; i < COS_ENTRIES; i++)
            t[i] = Q_W'(cos_units(i));
        return t;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* sv/ring_sensor_line_direction.sv */
// ring_sensor_line_direction: top level, sweep sequencer, pair lanes, merge and divide
// depends on rsld_pkg, rsld_lane, rsld_merge, rsld_div
`timescale 1ns / 1ps

// Takes one 32-bit sensor ring mask per item and returns the mean of the
// weighted midpoint unit vectors over the chosen sensor pairs, in signed
// Q2.14, with the number of pairs. Four lanes examine four candidate pairs
// (a, b..b+3) per cycle while the pair sweep runs over every a and every
// block of b, then the lane pipeline drains and a bit-serial divider forms
// the quotient, which is then loaded into the output register. One item is
// in work at a time; in_ready is high while idle, even when the previous
// result is still waiting in the output register, and a finished result
// waits in the divider until that register is free.
module ring_sensor_line_direction (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rsld_pkg::MASK_W-1:0]       sensor_mask,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rsld_pkg::DIR_W-1:0] dir_x,
    output logic signed [rsld_pkg::DIR_W-1:0] dir_y,
    output logic [rsld_pkg::COUNT_W-1:0]      pair_count
);

    rsld_pkg::state_t state_reg, state_next;

    logic [rsld_pkg::SWEEP_W-1:0]      sweep_reg, sweep_next;
    logic [rsld_pkg::DRAIN_W-1:0]      drain_reg, drain_next;
    logic [rsld_pkg::SENSOR_COUNT-1:0] mask_reg, mask_next;
    logic                              single_reg, single_next;
    logic                              lone_reg, lone_next;
    logic [rsld_pkg::SENSOR_W-1:0]     lone_idx_reg, lone_idx_next;

    logic                              out_valid_reg, out_valid_next;
    logic [rsld_pkg::DIR_W-1:0]        dir_x_reg, dir_x_next;
    logic [rsld_pkg::DIR_W-1:0]        dir_y_reg, dir_y_next;
    logic [rsld_pkg::COUNT_W-1:0]      count_reg, count_next;

    logic                              accept;
    logic                              sweep_last;
    logic                              sweep_issue;
    logic                              div_start;
    logic                              div_done_x, div_done_y;
    logic                              out_load;
    logic [rsld_pkg::DIR_W-1:0]        quot_x, quot_y;

    logic [rsld_pkg::MASK_W+rsld_pkg::SENSOR_COUNT-1:0] mask_wide;
    logic [rsld_pkg::SENSOR_COUNT-1:0] mask_in;
    logic [rsld_pkg::SENSOR_COUNT-1:0] run_starts;
    logic [rsld_pkg::SENSOR_W-1:0]     first_idx;

    logic [rsld_pkg::CNT_W+rsld_pkg::COUNT_W-1:0] count_wide;

    rsld_pkg::lane_ctx_t  ctx;
    rsld_pkg::lane_out_t  lane_res [rsld_pkg::LANE_COUNT];
    logic                 any_lane;

    logic signed [rsld_pkg::ACC_W-1:0] sum_x, sum_y;
    logic [rsld_pkg::CNT_W-1:0]        pairs;

    assign accept = in_valid && in_ready;

    // sensors beyond the ring size are ignored
    assign mask_wide = {{rsld_pkg::SENSOR_COUNT{1'b0}}, sensor_mask};
    assign mask_in   = mask_wide[rsld_pkg::SENSOR_COUNT-1:0];

    // a run starts where a lit sensor follows a dark one around the ring;
    // one start, or the whole ring lit, means a single run
    always_comb
    begin
        run_starts = mask_in & ~{mask_in[rsld_pkg::SENSOR_COUNT-2:0],
                                 mask_in[rsld_pkg::SENSOR_COUNT-1]};
        first_idx  = '0;
        for (int k = rsld_pkg::SENSOR_COUNT - 1; k >= 0; k--)
            if (mask_in[k])
                first_idx = rsld_pkg::SENSOR_W'(k);
    end

    // item context, captured on accept
    always_comb
    begin
        mask_next     = mask_reg;
        single_next   = single_reg;
        lone_next     = lone_reg;
        lone_idx_next = lone_idx_reg;
        if (accept) begin
            mask_next     = mask_in;
            single_next   = ((run_starts != '0) && ((run_starts & (run_starts - 1'b1)) == '0))
                            || (&mask_in);
            lone_next     = (mask_in != '0) && ((mask_in & (mask_in - 1'b1)) == '0);
            lone_idx_next = first_idx;
        end
    end

    // sweep index: upper bits pick sensor a, lower bits the block of b
    assign sweep_last = (sweep_reg == {rsld_pkg::SWEEP_W{1'b1}});

    always_comb
    begin
        sweep_next = sweep_reg;
        drain_next = drain_reg;
        if (accept)
            sweep_next = '0;
        else if (state_reg == rsld_pkg::ST_SWEEP)
            sweep_next = sweep_reg + rsld_pkg::SWEEP_W'(1);
        if (state_reg == rsld_pkg::ST_DRAIN)
            drain_next = drain_reg + rsld_pkg::DRAIN_W'(1);
        else
            drain_next = '0;
    end

    assign div_start = (state_reg == rsld_pkg::ST_DRAIN) && (drain_reg == rsld_pkg::DRAIN_LAST);
    assign out_load  = (((state_reg == rsld_pkg::ST_DIVIDE) && div_done_x)
                        || (state_reg == rsld_pkg::ST_HOLD))
                       && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsld_pkg::ST_IDLE:
                if (accept)
                    state_next = rsld_pkg::ST_SWEEP;
            rsld_pkg::ST_SWEEP:
                if (sweep_last)
                    state_next = rsld_pkg::ST_DRAIN;
            rsld_pkg::ST_DRAIN:
                if (div_start)
                    state_next = rsld_pkg::ST_DIVIDE;
            rsld_pkg::ST_DIVIDE:
                if (div_done_x)
                    state_next = out_load ? rsld_pkg::ST_IDLE : rsld_pkg::ST_HOLD;
            rsld_pkg::ST_HOLD:
                if (out_load)
                    state_next = rsld_pkg::ST_IDLE;
            default:
                state_next = rsld_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready    = 1'b0;
        sweep_issue = 1'b0;
        case (state_reg)
            rsld_pkg::ST_IDLE:   in_ready    = 1'b1;
            rsld_pkg::ST_SWEEP:  sweep_issue = 1'b1;
            rsld_pkg::ST_DRAIN,
            rsld_pkg::ST_DIVIDE,
            rsld_pkg::ST_HOLD:   in_ready    = 1'b0;
            default:             in_ready    = 1'b0;
        endcase
    end

    assign ctx.issue      = sweep_issue;
    assign ctx.mask       = mask_reg;
    assign ctx.single_run = single_reg;
    assign ctx.lone_mode  = lone_reg;
    assign ctx.lone_idx   = lone_idx_reg;
    assign ctx.a          = sweep_reg[rsld_pkg::SWEEP_W-1 -: rsld_pkg::SENSOR_W];

    // pair lanes, lane l takes b = block*LANE_COUNT + l
    for (genvar l = 0; l < rsld_pkg::LANE_COUNT; l++) begin : g_lane
        logic [rsld_pkg::SENSOR_W-1:0] lane_b;
        assign lane_b = rsld_pkg::SENSOR_W'(
            int'(sweep_reg[rsld_pkg::BLK_W-1:0]) * rsld_pkg::LANE_COUNT + l);
        rsld_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctx    (ctx),
            .b      (lane_b),
            .result (lane_res[l])
        );
    end

    always_comb
    begin
        any_lane = 1'b0;
        for (int l = 0; l < rsld_pkg::LANE_COUNT; l++)
            any_lane = any_lane | lane_res[l].valid;
    end

    rsld_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .lane_res (lane_res),
        .sum_x    (sum_x),
        .sum_y    (sum_y),
        .count    (pairs)
    );

    rsld_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_x),
        .count    (pairs),
        .done     (div_done_x),
        .quotient (quot_x)
    );

    rsld_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_y),
        .count    (pairs),
        .done     (div_done_y),
        .quotient (quot_y)
    );

    // output register; no pair gives a zero vector
    assign count_wide = {{rsld_pkg::COUNT_W{1'b0}}, pairs};

    always_comb
    begin
        dir_x_next     = dir_x_reg;
        dir_y_next     = dir_y_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load) begin
            out_valid_next = 1'b1;
            dir_x_next     = (pairs == '0) ? '0 : quot_x;
            dir_y_next     = (pairs == '0) ? '0 : quot_y;
            count_next     = count_wide[rsld_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= rsld_pkg::ST_IDLE;
            sweep_reg     <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        single_reg   <= single_next;
        lone_reg     <= lone_next;
        lone_idx_reg <= lone_idx_next;
        dir_x_reg    <= dir_x_next;
        dir_y_reg    <= dir_y_next;
        count_reg    <= count_next;
    end

    assign out_valid  = out_valid_reg;
    assign dir_x      = dir_x_reg;
    assign dir_y      = dir_y_reg;
    assign pair_count = count_reg;

    // an accepted item always starts the sweep
    a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == rsld_pkg::ST_SWEEP)
        else $error("accepted item did not start the sweep");

    // both dividers finish together, and only while dividing
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done_x || div_done_y) |-> (div_done_x && div_done_y
                                         && state_reg == rsld_pkg::ST_DIVIDE))
        else $error("divider finished out of step");

    // the lane pipeline is empty once division starts
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rsld_pkg::ST_DIVIDE |-> !any_lane)
        else $error("lane result arrived after the drain");

    // a lone sensor yields exactly one pair
    a_lone_one: assert property (@(posedge clk) disable iff (!rst_n)
        (div_start && lone_reg) |-> pairs == rsld_pkg::CNT_W'(1))
        else $error("lone sensor did not give one pair");

    // no pair means a zero vector
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pair_count == '0) |-> (dir_x == '0 && dir_y == '0))
        else $error("nonzero vector without pairs");

endmodule

/* sv/rsld_lane.sv */
// rsld_lane: one pair lane, pair selection, table lookup and weighted vector
// depends on rsld_pkg
`timescale 1ns / 1ps

module rsld_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsld_pkg::lane_ctx_t          ctx,
    input  logic [rsld_pkg::SENSOR_W-1:0] b,
    output rsld_pkg::lane_out_t          result
);

    logic [rsld_pkg::SENSOR_COUNT-1:0] seg;
    logic [rsld_pkg::SENSOR_COUNT-1:0] between;
    logic                              same_run;
    logic                              pair_ok;
    logic [rsld_pkg::SENSOR_W-1:0]     d;
    logic [rsld_pkg::H_W-1:0]          h;
    logic [rsld_pkg::H_W-1:0]          s;
    logic [rsld_pkg::COS_IDX_W-1:0]    w_idx;
    logic [rsld_pkg::COS_IDX_W-1:0]    cx_idx;
    logic [rsld_pkg::COS_IDX_W-1:0]    cy_idx;
    logic signed [rsld_pkg::Q_W-1:0]   w_raw;
    logic [rsld_pkg::MAG_W-1:0]        w_mag;

    logic                              v1_reg, v1_next;
    logic [rsld_pkg::MAG_W-1:0]        w1_reg, w1_next;
    logic signed [rsld_pkg::Q_W-1:0]   cx1_reg, cx1_next;
    logic signed [rsld_pkg::Q_W-1:0]   cy1_reg, cy1_next;

    logic                              v2_reg, v2_next;
    logic signed [rsld_pkg::Q_W-1:0]   px2_reg, px2_next;
    logic signed [rsld_pkg::Q_W-1:0]   py2_reg, py2_next;

    logic [rsld_pkg::MAG_W-1:0]        mx, my;
    logic [2*rsld_pkg::MAG_W-1:0]      prod_x, prod_y;
    logic [rsld_pkg::MAG_W:0]          rx, ry;

    // run membership: contiguous lit path inside [a,b] or around the wrap
    always_comb
    begin
        for (int i = 0; i < rsld_pkg::SENSOR_COUNT; i++) begin
            seg[i]     = (i >= int'(ctx.a)) && (i <= int'(b));
            between[i] = (i > int'(ctx.a)) && (i < int'(b));
        end
        same_run = (&(ctx.mask | ~seg)) || (&(ctx.mask | between));
        if (ctx.lone_mode)
            pair_ok = (ctx.a == ctx.lone_idx) && (b == ctx.lone_idx);
        else
            pair_ok = ctx.mask[ctx.a] && ctx.mask[b] && (b > ctx.a)
                      && (ctx.single_run || !same_run);
    end

    // circular midpoint in half-sensor steps
    always_comb
    begin
        d = b - ctx.a;
        h = rsld_pkg::H_W'(ctx.a) + rsld_pkg::H_W'(b);
        if ({1'b0, d, 1'b0} > (rsld_pkg::SENSOR_W + 2)'(rsld_pkg::SENSOR_COUNT))
            h = h + rsld_pkg::H_W'(rsld_pkg::SENSOR_COUNT);
        if (h >= rsld_pkg::H_W'(2 * rsld_pkg::SENSOR_COUNT))
            h = h - rsld_pkg::H_W'(2 * rsld_pkg::SENSOR_COUNT);
        s = {h[rsld_pkg::H_W-2:0], 1'b0} + rsld_pkg::H_W'(3 * rsld_pkg::SENSOR_COUNT);
        if (s >= rsld_pkg::H_W'(4 * rsld_pkg::SENSOR_COUNT))
            s = s - rsld_pkg::H_W'(4 * rsld_pkg::SENSOR_COUNT);
        w_idx  = rsld_pkg::COS_IDX_W'({d, 1'b0});
        cx_idx = rsld_pkg::COS_IDX_W'({h, 1'b0});
        cy_idx = s[rsld_pkg::COS_IDX_W-1:0];
        w_raw  = rsld_pkg::COS_TABLE[w_idx];
        w_mag  = w_raw[rsld_pkg::Q_W-1] ? rsld_pkg::MAG_W'(-w_raw)
                                         : rsld_pkg::MAG_W'(w_raw);
        v1_next  = ctx.issue && pair_ok;
        w1_next  = w_mag;
        cx1_next = rsld_pkg::COS_TABLE[cx_idx];
        cy1_next = rsld_pkg::COS_TABLE[cy_idx];
    end

    // weight times cosine, rounded half up on the magnitude
    always_comb
    begin
        mx = cx1_reg[rsld_pkg::Q_W-1] ? rsld_pkg::MAG_W'(-cx1_reg)
                                       : rsld_pkg::MAG_W'(cx1_reg);
        my = cy1_reg[rsld_pkg::Q_W-1] ? rsld_pkg::MAG_W'(-cy1_reg)
                                       : rsld_pkg::MAG_W'(cy1_reg);
        prod_x = w1_reg * mx + ((2*rsld_pkg::MAG_W)'(1) << (rsld_pkg::ACC_BITS - 1));
        prod_y = w1_reg * my + ((2*rsld_pkg::MAG_W)'(1) << (rsld_pkg::ACC_BITS - 1));
        rx = prod_x[rsld_pkg::ACC_BITS +: rsld_pkg::MAG_W+1];
        ry = prod_y[rsld_pkg::ACC_BITS +: rsld_pkg::MAG_W+1];
        px2_next = cx1_reg[rsld_pkg::Q_W-1] ? -rsld_pkg::Q_W'(rx) : rsld_pkg::Q_W'(rx);
        py2_next = cy1_reg[rsld_pkg::Q_W-1] ? -rsld_pkg::Q_W'(ry) : rsld_pkg::Q_W'(ry);
        v2_next  = v1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg  <= w1_next;
        cx1_reg <= cx1_next;
        cy1_reg <= cy1_next;
        px2_reg <= px2_next;
        py2_reg <= py2_next;
    end

    assign result.valid = v2_reg;
    assign result.px    = px2_reg;
    assign result.py    = py2_reg;

endmodule

/* sv/rsld_merge.sv */
// rsld_merge: sums lane vectors and pair counts for one item
// depends on rsld_pkg
`timescale 1ns / 1ps

module rsld_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  rsld_pkg::lane_out_t                lane_res [rsld_pkg::LANE_COUNT],
    output logic signed [rsld_pkg::ACC_W-1:0]  sum_x,
    output logic signed [rsld_pkg::ACC_W-1:0]  sum_y,
    output logic [rsld_pkg::CNT_W-1:0]         count
);

    logic signed [rsld_pkg::ACC_W-1:0] sx_reg, sx_next;
    logic signed [rsld_pkg::ACC_W-1:0] sy_reg, sy_next;
    logic [rsld_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [rsld_pkg::LCNT_W-1:0]       hits;

    always_comb
    begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        hits    = '0;
        for (int l = 0; l < rsld_pkg::LANE_COUNT; l++) begin
            if (lane_res[l].valid) begin
                sx_next = sx_next + rsld_pkg::ACC_W'(lane_res[l].px);
                sy_next = sy_next + rsld_pkg::ACC_W'(lane_res[l].py);
                hits    = hits + rsld_pkg::LCNT_W'(1);
            end
        end
        cnt_next = cnt_reg + rsld_pkg::CNT_W'(hits);
        if (clear) begin
            sx_next  = '0;
            sy_next  = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
    end

    assign sum_x = sx_reg;
    assign sum_y = sy_reg;
    assign count = cnt_reg;

endmodule

/* sv/rsld_div.sv */
// rsld_div: bit-serial signed divide of a vector sum by the shifted pair count
// depends on rsld_pkg
`timescale 1ns / 1ps

module rsld_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rsld_pkg::ACC_W-1:0] dividend,
    input  logic [rsld_pkg::CNT_W-1:0]        count,
    output logic                              done,
    output logic [rsld_pkg::DIR_W-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rsld_pkg::DSTEP_W-1:0]      step_reg, step_next;
    logic                              neg_reg, neg_next;
    logic [rsld_pkg::ACC_W-1:0]        mag_reg, mag_next;
    logic [rsld_pkg::ACC_W-1:0]        q_reg, q_next;
    logic [rsld_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [rsld_pkg::DIVISOR_W-1:0]    dsr_reg, dsr_next;
    logic [rsld_pkg::DIVISOR_W:0]      rem_sh;
    logic [rsld_pkg::ACC_W-1:0]        q_signed;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, mag_reg[rsld_pkg::ACC_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = rsld_pkg::DSTEP_W'(rsld_pkg::ACC_W - 1);
            neg_next  = dividend[rsld_pkg::ACC_W-1];
            mag_next  = dividend[rsld_pkg::ACC_W-1] ? rsld_pkg::ACC_W'(-dividend)
                                                    : rsld_pkg::ACC_W'(dividend);
            q_next    = '0;
            rem_next  = '0;
            dsr_next  = {count, {rsld_pkg::DIV_SHIFT{1'b0}}};
        end else if (busy_reg) begin
            mag_next = {mag_reg[rsld_pkg::ACC_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rsld_pkg::DIVISOR_W'(rem_sh - {1'b0, dsr_reg});
                q_next   = {q_reg[rsld_pkg::ACC_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[rsld_pkg::DIVISOR_W-1:0];
                q_next   = {q_reg[rsld_pkg::ACC_W-2:0], 1'b0};
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - rsld_pkg::DSTEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign q_signed = neg_reg ? -q_reg : q_reg;
    assign quotient = q_signed[rsld_pkg::DIR_W-1:0];
    assign done     = done_reg;

endmodule
